@@ rtl/core/ccm_pkg.sv @@
// Shared types and constants for the classifier confusion metrics block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package ccm_pkg;

  // Default saturation limit of the four outcome counters
  localparam longint unsigned CCM_COUNT_MAX = 64'd65535;

  localparam int CCM_SCORE_W  = 16;
  localparam int CCM_COUNT_W  = 16;  // width of the emitted counts
  localparam int CCM_FRAC_W   = 16;  // fraction bits of a ratio
  localparam int CCM_RATIO_W  = CCM_FRAC_W + 1;

  localparam logic [CCM_SCORE_W-1:0] CCM_THRESH_RESET = 16'h8000;
  localparam logic [CCM_RATIO_W-1:0] CCM_RATIO_ONE    = 17'h10000;

  // Ratio computed by the shared divider, in the order they are run
  typedef enum logic [1:0] {
    RATIO_ACC  = 2'd0,
    RATIO_PREC = 2'd1,
    RATIO_REC  = 2'd2,
    RATIO_F1   = 2'd3
  } ccm_ratio_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } ccm_state_e;

  // Status from the serial divider to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ccm_div_status_t;

endpackage

`default_nettype wire

@@ rtl/core/ccm_counters.sv @@
// Threshold compare and the four saturating outcome counters with overflow flag.
// Depends on ccm_pkg.
`default_nettype none

module ccm_counters
  import ccm_pkg::*;
#(
  parameter longint unsigned COUNT_MAX = CCM_COUNT_MAX,
  localparam int CNT_W = $clog2(COUNT_MAX + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [CCM_SCORE_W-1:0] score_i,
  input  wire logic                   label_i,
  input  wire logic                   last_i,
  input  wire logic [CCM_SCORE_W-1:0] threshold_i,
  output logic      [CNT_W-1:0]       tp_o,
  output logic      [CNT_W-1:0]       fp_o,
  output logic      [CNT_W-1:0]       tn_o,
  output logic      [CNT_W-1:0]       fn_o,
  output logic                        overflow_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(COUNT_MAX);

  logic [CNT_W-1:0] tp_q, fp_q, tn_q, fn_q;
  logic [CNT_W-1:0] tp_d, fp_d, tn_d, fn_d;
  logic             ovf_q, ovf_d;
  logic             pred;
  logic             inc_tp, inc_fp, inc_tn, inc_fn;
  logic             full_tp, full_fp, full_tn, full_fn;

  assign pred   = score_i >= threshold_i;
  assign inc_tp = pred & label_i;
  assign inc_fp = pred & ~label_i;
  assign inc_tn = ~pred & ~label_i;
  assign inc_fn = ~pred & label_i;

  assign full_tp = tp_q >= MaxCnt;
  assign full_fp = fp_q >= MaxCnt;
  assign full_tn = tn_q >= MaxCnt;
  assign full_fn = fn_q >= MaxCnt;

  // Post-update values: the sample itself counts before a report
  always_comb begin
    tp_d  = (inc_tp && !full_tp) ? tp_q + CNT_W'(1) : tp_q;
    fp_d  = (inc_fp && !full_fp) ? fp_q + CNT_W'(1) : fp_q;
    tn_d  = (inc_tn && !full_tn) ? tn_q + CNT_W'(1) : tn_q;
    fn_d  = (inc_fn && !full_fn) ? fn_q + CNT_W'(1) : fn_q;
    ovf_d = ovf_q | (inc_tp & full_tp) | (inc_fp & full_fp)
                  | (inc_tn & full_tn) | (inc_fn & full_fn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= '0;
      fp_q  <= '0;
      tn_q  <= '0;
      fn_q  <= '0;
      ovf_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        // clear for the next evaluation set
        tp_q  <= '0;
        fp_q  <= '0;
        tn_q  <= '0;
        fn_q  <= '0;
        ovf_q <= 1'b0;
      end else begin
        tp_q  <= tp_d;
        fp_q  <= fp_d;
        tn_q  <= tn_d;
        fn_q  <= fn_d;
        ovf_q <= ovf_d;
      end
    end
  end

  assign tp_o       = tp_d;
  assign fp_o       = fp_d;
  assign tn_o       = tn_d;
  assign fn_o       = fn_d;
  assign overflow_o = ovf_d;

endmodule

`default_nettype wire

@@ rtl/core/ccm_serial_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle of (num << FRAC) / den.
// Expects num <= den; a zero denominator yields zero. Depends on ccm_pkg.
`default_nettype none

module ccm_serial_div
  import ccm_pkg::*;
#(
  parameter int DEN_W = 18
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [DEN_W-1:0]       num_i,
  input  wire logic [DEN_W-1:0]       den_i,
  output ccm_div_status_t             status_o,
  output logic      [CCM_RATIO_W-1:0] quotient_o
);

  localparam int RW   = DEN_W + 1;
  localparam int SC_W = $clog2(CCM_FRAC_W + 1);

  logic [RW-1:0]          rem_q, rem_d, trial;
  logic [DEN_W-1:0]       den_q;
  logic [CCM_RATIO_W-1:0] quo_q;
  logic [SC_W-1:0]        step_q;
  logic                   busy_q, done_q, zero_q;
  logic                   ge;

  // First step compares num itself (integer bit), later steps shift in zeros
  assign trial = (step_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? trial - {1'b0, den_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == SC_W'(CCM_FRAC_W)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + SC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      zero_q <= den_i == '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[CCM_RATIO_W-2:0], ge};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = zero_q ? '0 : quo_q;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("divider did not start");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !zero_q && step_q != '0) |-> (rem_q < {1'b0, den_q}))
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ rtl/core/classifier_confusion_metrics.sv @@
// Classifier confusion metrics: one sample per cycle while not busy; on the last sample of a set,
// accuracy, precision, recall and F1 come from one bit-serial divider run four times.
// Sequence: after the last sample is accepted, each of the 4 ratios takes a load, the
// quotient bits and a hand-off (ST_LOAD, ST_WAIT); then ST_EMIT strobes the result.
// Throughput: 1 sample per cycle while idle; busy_o holds off requests after a last until the result strobe.
// Reset clears counters, overflow flag and sequencer; threshold resets to 0x8000.
`default_nettype none

module classifier_confusion_metrics
  import ccm_pkg::*;
#(
  parameter longint unsigned COUNT_MAX = CCM_COUNT_MAX
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [CCM_SCORE_W-1:0] risk_score_i,
  input  wire logic                   actual_label_i,
  input  wire logic                   last_sample_i,
  input  wire logic                   decision_threshold_we_i,
  input  wire logic [CCM_SCORE_W-1:0] decision_threshold_i,
  output logic                        result_valid_o,
  output logic      [CCM_COUNT_W-1:0] true_pos_o,
  output logic      [CCM_COUNT_W-1:0] false_pos_o,
  output logic      [CCM_COUNT_W-1:0] true_neg_o,
  output logic      [CCM_COUNT_W-1:0] false_neg_o,
  output logic      [CCM_RATIO_W-1:0] accuracy_ratio_o,
  output logic      [CCM_RATIO_W-1:0] precision_ratio_o,
  output logic      [CCM_RATIO_W-1:0] recall_ratio_o,
  output logic      [CCM_RATIO_W-1:0] f1_ratio_o,
  output logic                        count_overflow_o
);

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int DEN_W = CNT_W + 2;
  localparam int XW    = (CNT_W > CCM_COUNT_W) ? CNT_W : CCM_COUNT_W;

  ccm_state_e state_q, state_d;
  ccm_ratio_e idx_q;

  logic [CCM_SCORE_W-1:0] thresh_q;
  logic [CNT_W-1:0]       tp_n, fp_n, tn_n, fn_n;
  logic                   ovf_n;
  logic [CNT_W-1:0]       tp_q, fp_q, tn_q, fn_q;
  logic                   ovf_q;
  logic [CCM_RATIO_W-1:0] ratio_q [4];
  logic                   accept, div_start;
  logic [DEN_W-1:0]       num, den;
  logic [DEN_W-1:0]       tp_x, fp_x, tn_x, fn_x;
  ccm_div_status_t        div_status;
  logic [CCM_RATIO_W-1:0] quotient;
  logic [XW-1:0]          tp_w, fp_w, tn_w, fn_w;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= CCM_THRESH_RESET;
    end else if (decision_threshold_we_i) begin
      thresh_q <= decision_threshold_i;
    end
  end

  ccm_counters #(
    .COUNT_MAX (COUNT_MAX)
  ) u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .score_i     (risk_score_i),
    .label_i     (actual_label_i),
    .last_i      (last_sample_i),
    .threshold_i (thresh_q),
    .tp_o        (tp_n),
    .fp_o        (fp_n),
    .tn_o        (tn_n),
    .fn_o        (fn_n),
    .overflow_o  (ovf_n)
  );

  // Operand select for the ratio being computed
  assign tp_x = DEN_W'(tp_q);
  assign fp_x = DEN_W'(fp_q);
  assign tn_x = DEN_W'(tn_q);
  assign fn_x = DEN_W'(fn_q);

  always_comb begin
    unique case (idx_q)
      RATIO_ACC: begin
        num = tp_x + tn_x;
        den = (tp_x + fp_x) + (tn_x + fn_x);
      end
      RATIO_PREC: begin
        num = tp_x;
        den = tp_x + fp_x;
      end
      RATIO_REC: begin
        num = tp_x;
        den = tp_x + fn_x;
      end
      RATIO_F1: begin
        num = {tp_x[DEN_W-2:0], 1'b0};
        den = {tp_x[DEN_W-2:0], 1'b0} + (fp_x + fn_x);
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  ccm_serial_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (num),
    .den_i      (den),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && last_sample_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_status.done) begin
          state_d = (idx_q == RATIO_F1) ? ST_EMIT : ST_LOAD;
        end
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy_o         = 1'b1;
    div_start      = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_LOAD: div_start = 1'b1;
      ST_WAIT: ;
      ST_EMIT: result_valid_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= RATIO_ACC;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        idx_q <= RATIO_ACC;
      end else if (state_q == ST_WAIT && div_status.done) begin
        idx_q <= ccm_ratio_e'(idx_q + 2'd1);
      end
    end
  end

  // Snapshot the post-update counts of the last sample; hold until reported
  always_ff @(posedge clk_i) begin
    if (accept && last_sample_i) begin
      tp_q  <= tp_n;
      fp_q  <= fp_n;
      tn_q  <= tn_n;
      fn_q  <= fn_n;
      ovf_q <= ovf_n;
    end
    if (state_q == ST_WAIT && div_status.done) begin
      ratio_q[idx_q] <= quotient;
    end
  end

  assign tp_w = XW'(tp_q);
  assign fp_w = XW'(fp_q);
  assign tn_w = XW'(tn_q);
  assign fn_w = XW'(fn_q);

  assign true_pos_o        = tp_w[CCM_COUNT_W-1:0];
  assign false_pos_o       = fp_w[CCM_COUNT_W-1:0];
  assign true_neg_o        = tn_w[CCM_COUNT_W-1:0];
  assign false_neg_o       = fn_w[CCM_COUNT_W-1:0];
  assign accuracy_ratio_o  = ratio_q[RATIO_ACC];
  assign precision_ratio_o = ratio_q[RATIO_PREC];
  assign recall_ratio_o    = ratio_q[RATIO_REC];
  assign f1_ratio_o        = ratio_q[RATIO_F1];
  assign count_overflow_o  = ovf_q;

`ifndef NO_ASSERTIONS
  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o) else $error("still busy after result strobe");

  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_sample_i) |=> busy_o)
    else $error("last request did not start metric computation");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (accuracy_ratio_o <= CCM_RATIO_ONE && precision_ratio_o <= CCM_RATIO_ONE
                        && recall_ratio_o <= CCM_RATIO_ONE && f1_ratio_o <= CCM_RATIO_ONE))
    else $error("ratio above 1.0");

  a_div_idle_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy) else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for classifier_confusion_metrics: streams labeled scores
// in sets, predicts the counts and Q1.16 ratios, and checks every strobed result.
// Depends on ccm_pkg and the classifier_confusion_metrics RTL.
`timescale 1ns / 100ps

module tb_top;
  import ccm_pkg::*;

  typedef struct packed {
    logic [CCM_COUNT_W-1:0] tp;
    logic [CCM_COUNT_W-1:0] fp;
    logic [CCM_COUNT_W-1:0] tn;
    logic [CCM_COUNT_W-1:0] fn;
    logic [CCM_RATIO_W-1:0] acc;
    logic [CCM_RATIO_W-1:0] prec;
    logic [CCM_RATIO_W-1:0] rec;
    logic [CCM_RATIO_W-1:0] f1;
    logic                   ovf;
  } metrics_t;

  class metrics_scoreboard;
    logic [CCM_SCORE_W-1:0] threshold;
    logic [CCM_COUNT_W-1:0] tp_cnt, fp_cnt, tn_cnt, fn_cnt;
    logic                   ovf_seen;
    metrics_t               expected_metrics[$];
    int                     errors;

    function new();
      threshold = CCM_THRESH_RESET;
      errors    = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      tp_cnt   = '0;
      fp_cnt   = '0;
      tn_cnt   = '0;
      fn_cnt   = '0;
      ovf_seen = 1'b0;
    endfunction

    // Saturate at the counter limit and flag it
    function logic [CCM_COUNT_W-1:0] bump(logic [CCM_COUNT_W-1:0] cnt);
      if (longint'(cnt) >= CCM_COUNT_MAX) begin
        ovf_seen = 1'b1;
        return cnt;
      end
      return cnt + 1'b1;
    endfunction

    function logic [CCM_RATIO_W-1:0] ratio_q16(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return '0;
      q = (num << CCM_FRAC_W) / den;
      if (q > CCM_RATIO_ONE) q = CCM_RATIO_ONE;
      return q[CCM_RATIO_W-1:0];
    endfunction

    function void note_sample(logic [CCM_SCORE_W-1:0] score, logic label, logic last);
      metrics_t        m;
      longint unsigned tp, fp, tn, fn;
      if (score >= threshold) begin
        if (label) tp_cnt = bump(tp_cnt);
        else       fp_cnt = bump(fp_cnt);
      end else begin
        if (label) fn_cnt = bump(fn_cnt);
        else       tn_cnt = bump(tn_cnt);
      end
      if (!last) return;
      tp = tp_cnt;
      fp = fp_cnt;
      tn = tn_cnt;
      fn = fn_cnt;
      m.tp   = tp_cnt;
      m.fp   = fp_cnt;
      m.tn   = tn_cnt;
      m.fn   = fn_cnt;
      m.acc  = ratio_q16(tp + tn, tp + fp + tn + fn);
      m.prec = ratio_q16(tp, tp + fp);
      m.rec  = ratio_q16(tp, tp + fn);
      m.f1   = ratio_q16(2 * tp, 2 * tp + fp + fn);
      m.ovf  = ovf_seen;
      expected_metrics.push_back(m);
      clear_counts();
    endfunction

    function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_metrics(metrics_t got);
      metrics_t exp_m;
      if (expected_metrics.size() == 0) begin
        $error("result strobe with no set pending");
        errors++;
        return;
      end
      exp_m = expected_metrics.pop_front();
      check_field("true_pos", exp_m.tp, got.tp);
      check_field("false_pos", exp_m.fp, got.fp);
      check_field("true_neg", exp_m.tn, got.tn);
      check_field("false_neg", exp_m.fn, got.fn);
      check_field("accuracy_ratio", exp_m.acc, got.acc);
      check_field("precision_ratio", exp_m.prec, got.prec);
      check_field("recall_ratio", exp_m.rec, got.rec);
      check_field("f1_ratio", exp_m.f1, got.f1);
      check_field("count_overflow", exp_m.ovf, got.ovf);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [CCM_SCORE_W-1:0] risk_score_i = '0;
  logic                   actual_label_i = 1'b0;
  logic                   last_sample_i = 1'b0;
  logic                   decision_threshold_we_i = 1'b0;
  logic [CCM_SCORE_W-1:0] decision_threshold_i = '0;
  logic                   result_valid_o;
  logic [CCM_COUNT_W-1:0] true_pos_o, false_pos_o, true_neg_o, false_neg_o;
  logic [CCM_RATIO_W-1:0] accuracy_ratio_o, precision_ratio_o, recall_ratio_o, f1_ratio_o;
  logic                   count_overflow_o;

  metrics_scoreboard sb;
  bit                no_gaps;

  classifier_confusion_metrics dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .start_i                 (start_i),
    .busy_o                  (busy_o),
    .risk_score_i            (risk_score_i),
    .actual_label_i          (actual_label_i),
    .last_sample_i           (last_sample_i),
    .decision_threshold_we_i (decision_threshold_we_i),
    .decision_threshold_i    (decision_threshold_i),
    .result_valid_o          (result_valid_o),
    .true_pos_o              (true_pos_o),
    .false_pos_o             (false_pos_o),
    .true_neg_o              (true_neg_o),
    .false_neg_o             (false_neg_o),
    .accuracy_ratio_o        (accuracy_ratio_o),
    .precision_ratio_o       (precision_ratio_o),
    .recall_ratio_o          (recall_ratio_o),
    .f1_ratio_o              (f1_ratio_o),
    .count_overflow_o        (count_overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : result_monitor
    metrics_t got;
    if (rst_ni && result_valid_o) begin
      got.tp   = true_pos_o;
      got.fp   = false_pos_o;
      got.tn   = true_neg_o;
      got.fn   = false_neg_o;
      got.acc  = accuracy_ratio_o;
      got.prec = precision_ratio_o;
      got.rec  = recall_ratio_o;
      got.f1   = f1_ratio_o;
      got.ovf  = count_overflow_o;
      sb.check_metrics(got);
    end
  end

  // Hold the request until the block takes it
  task automatic send_sample(logic [CCM_SCORE_W-1:0] score, logic label, logic last);
    @(negedge clk_i);
    start_i        = 1'b1;
    risk_score_i   = score;
    actual_label_i = label;
    last_sample_i  = last;
    do @(posedge clk_i); while (busy_o);
    sb.note_sample(score, label, last);
  endtask

  task automatic pause(int n);
    if (n == 0) return;
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias scores toward the decision boundary and the range ends
  function automatic logic [CCM_SCORE_W-1:0] rand_score(logic [CCM_SCORE_W-1:0] thr);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return thr - 1'b1;
      4, 5:    return thr + CCM_SCORE_W'($urandom_range(0, 16)) - CCM_SCORE_W'(8);
      default: return CCM_SCORE_W'($urandom);
    endcase
  endfunction

  // Stop sending and let the divider finish before touching the register
  task automatic drain();
    pause(1);
    while (sb.expected_metrics.size() != 0) @(posedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [CCM_SCORE_W-1:0] thr);
    drain();
    @(negedge clk_i);
    decision_threshold_we_i = 1'b1;
    decision_threshold_i    = thr;
    @(negedge clk_i);
    decision_threshold_we_i = 1'b0;
    sb.threshold = thr;
  endtask

  task automatic random_phase(int items);
    int count, len, r;
    count   = 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (count < items) begin
      r = $urandom_range(0, 99);
      if (r < 50)      len = $urandom_range(1, 8);
      else if (r < 85) len = $urandom_range(9, 30);
      else             len = $urandom_range(31, 120);
      // trim the final set to the phase budget
      if (len > items - count) len = items - count;
      for (int i = 0; i < len; i++) begin
        send_sample(rand_score(sb.threshold), 1'($urandom), i == len - 1);
        pause(rand_gap());
      end
      count += len;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [CCM_SCORE_W-1:0] thr;
    sb = new();
    no_gaps = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets under the reset threshold
    send_sample(16'hFFFF, 1'b1, 1'b1);   // lone true positive
    pause(rand_gap());
    send_sample(16'h0000, 1'b0, 1'b1);   // lone true negative
    send_sample(16'h8000, 1'b0, 1'b1);   // score equal to threshold is positive
    pause(rand_gap());
    send_sample(16'h7FFF, 1'b1, 1'b1);   // just below threshold
    send_sample(16'hAAAA, 1'b1, 1'b0);
    send_sample(16'h5555, 1'b1, 1'b0);
    pause(3);
    send_sample(16'h5555, 1'b0, 1'b0);
    send_sample(16'hAAAA, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b1);
    send_sample(16'h0000, 1'b1, 1'b0);   // no positive predictions at all
    send_sample(16'h1234, 1'b1, 1'b1);
    send_sample(16'hFFFF, 1'b0, 1'b0);   // no actual positives at all
    send_sample(16'hC000, 1'b0, 1'b1);

    random_phase(60);
    write_threshold(16'h0000);
    random_phase(70);
    write_threshold(16'hFFFF);
    random_phase(70);
    write_threshold(16'h0001);
    random_phase(60);
    write_threshold(16'hFFFE);
    random_phase(60);
    for (int p = 0; p < 4; p++) begin
      thr = CCM_SCORE_W'($urandom);
      write_threshold(thr);
      random_phase(70);
    end

    write_threshold(CCM_THRESH_RESET);
    random_phase(30);

    drain();
    if (sb.errors == 0 && sb.expected_metrics.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
